/* hdl/sequential_array_list_defines.svh */
// assertion helpers for the list block
`ifndef SEQUENTIAL_ARRAY_LIST_DEFINES_SVH
`define SEQUENTIAL_ARRAY_LIST_DEFINES_SVH

// same-cycle implication
`define SAL_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("list block check failed");

// next-cycle implication
`define SAL_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("list block check failed");

`endif

/* hdl/sal_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 16;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 11;

  // cells per group in the removed-value pick tree
  localparam int GROUP = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_INS_POS  = 3'd2,
    FN_REM_HEAD = 3'd3,
    FN_REM_TAIL = 3'd4,
    FN_REM_POS  = 3'd5
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage

`default_nettype wire

/* hdl/sal_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sal_in_if import sal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  entry_value;

  modport source (output valid, output func, output position, output entry_value,
                  input ready);
  modport sink (input valid, input func, input position, input entry_value,
                output ready);
endinterface

interface sal_out_if import sal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] removed_value;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output removed_value, output status,
                  output entry_count, input ready);
  modport sink (input valid, input removed_value, input status, input entry_count,
                output ready);
endinterface

`default_nettype wire

/* hdl/sal_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sal_cell import sal_pkg::*; #(
  parameter int INDEX = 0,
  parameter int VW    = 16,
  parameter int PW    = 11
) (
  input  wire logic          clk,
  input  wire cell_op_t      op,
  input  wire logic [PW-1:0] at,
  input  wire logic [VW-1:0] din,
  input  wire logic [VW-1:0] left,
  input  wire logic [VW-1:0] right,
  output logic      [VW-1:0] q,
  output logic               hit
);

  logic [VW-1:0] q_r;
  logic [VW-1:0] q_nxt;
  logic          above;

  assign hit   = (at == PW'(INDEX));
  assign above = (at < PW'(INDEX));

  always_comb begin
    q_nxt = q_r;
    if (op.ins) begin
      if (above) begin
        q_nxt = left;
      end else if (hit) begin
        q_nxt = din;
      end
    end else if (op.rem && (hit || above)) begin
      q_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* hdl/sal_pick.sv */
`timescale 1ns / 1ps
`default_nettype none

module sal_pick import sal_pkg::*; #(
  parameter int G  = 32,
  parameter int VW = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [G-1:0][VW-1:0]  q,
  input  wire logic [G-1:0]          hit,
  output logic      [VW-1:0]         grp
);

  logic [VW-1:0] grp_r;
  logic [VW-1:0] grp_nxt;

  // at most one cell of the whole row is hit
  always_comb begin
    grp_nxt = '0;
    for (int i = 0; i < G; i++) begin
      grp_nxt = grp_nxt | (q[i] & {VW{hit[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
    end
  end

  assign grp = grp_r;

endmodule

`default_nettype wire

/* hdl/sequential_array_list.sv */
// channel   dir  payload                                 beat when
// in_ch     in   func, position, entry_value             valid && ready
// out_ch    out  removed_value, status, entry_count      valid && ready
//
// one request per cycle while in_ch.ready is high; its result is registered at the
// group capture of the removed cell, then after the final or over the groups.
// every cell shifts in parallel on the input beat, so no request waits on another.
// reset clears the count and the pipeline valids only; slot contents are not cleared.
// in_ch.ready drops while a result sits in the output register and out_ch.ready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "sequential_array_list_defines.svh"

module sequential_array_list import sal_pkg::*; #(
  parameter int CAPACITY    = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  sal_in_if.sink   in_ch,
  sal_out_if.source out_ch
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int NG = (CAPACITY + GROUP - 1) / GROUP;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] at;
  logic          ins;
  logic          rem;
  status_t       st;
  func_t         fn;
  logic          acc;
  logic          adv;
  logic [VW-1:0] din;
  cell_op_t      op;

  logic [NG*GROUP-1:0][VW-1:0] cell_q;
  logic [NG*GROUP-1:0]         cell_hit;
  logic [NG-1:0][VW-1:0]       grp;
  logic [VW-1:0]               rem_val;
  logic [VAL_W-1:0]            rem_out;

  logic             s1_valid_r;
  logic             s1_rem_r;
  status_t          s1_st_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_removed_r;
  status_t          out_st_r;
  logic [CNT_W-1:0] out_cnt_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;

  assign fn      = func_t'(in_ch.func);
  assign cnt_ext = PW'(count_r);
  assign pos_ext = PW'(in_ch.position);

  generate
    if (VW > VAL_W) begin : g_din_wide
      assign din = {{(VW-VAL_W){1'b0}}, in_ch.entry_value};
    end else begin : g_din_narrow
      assign din = in_ch.entry_value[VW-1:0];
    end
  endgenerate

  // request decode and error checks against the current count
  always_comb begin
    ins = 1'b0;
    rem = 1'b0;
    at  = '0;
    st  = ST_OK;
    unique case (fn) inside
      FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
        at = (fn == FN_INS_HEAD) ? '0 : (fn == FN_INS_TAIL) ? cnt_ext : pos_ext;
        if (count_r == CW'(CAPACITY)) begin
          st = ST_FULL;
        end else if (at > cnt_ext) begin
          st = ST_RANGE;
        end else begin
          ins = 1'b1;
        end
      end
      FN_REM_HEAD, FN_REM_TAIL, FN_REM_POS: begin
        if (count_r == '0) begin
          st = ST_EMPTY;
        end else begin
          at = (fn == FN_REM_HEAD) ? '0 :
               (fn == FN_REM_TAIL) ? (cnt_ext - PW'(1)) : pos_ext;
          if (at >= cnt_ext) begin
            st = ST_RANGE;
          end else begin
            rem = 1'b1;
          end
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign op.ins = ins && acc;
  assign op.rem = rem && acc;

  always_comb begin
    count_nxt = count_r;
    if (ins) begin
      count_nxt = count_r + CW'(1);
    end else if (rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

  // row of cells, padded with empty slots up to a whole number of groups
  generate
    for (genvar i = 0; i < NG*GROUP; i++) begin : g_cell
      if (i < CAPACITY) begin : g_real
        logic [VW-1:0] lft;
        logic [VW-1:0] rgt;
        if (i == 0) begin : g_head
          assign lft = '0;
        end else begin : g_mid_l
          assign lft = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
          assign rgt = '0;
        end else begin : g_mid_r
          assign rgt = cell_q[i+1];
        end
        sal_cell #(
          .INDEX (i),
          .VW    (VW),
          .PW    (PW)
        ) u_cell (
          .clk   (clk),
          .op    (op),
          .at    (at),
          .din   (din),
          .left  (lft),
          .right (rgt),
          .q     (cell_q[i]),
          .hit   (cell_hit[i])
        );
      end else begin : g_pad
        assign cell_q[i]   = '0;
        assign cell_hit[i] = 1'b0;
      end
    end

    for (genvar g = 0; g < NG; g++) begin : g_grp
      sal_pick #(
        .G  (GROUP),
        .VW (VW)
      ) u_pick (
        .clk (clk),
        .en  (acc),
        .q   (cell_q[g*GROUP +: GROUP]),
        .hit (cell_hit[g*GROUP +: GROUP]),
        .grp (grp[g])
      );
    end
  endgenerate

  always_comb begin
    rem_val = '0;
    for (int g = 0; g < NG; g++) begin
      rem_val = rem_val | grp[g];
    end
  end

  generate
    if (VW >= VAL_W) begin : g_out_wide
      assign rem_out = rem_val[VAL_W-1:0];
    end else begin : g_out_narrow
      assign rem_out = {{(VAL_W-VW){1'b0}}, rem_val};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= acc;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rem_r <= rem;
      s1_st_r  <= st;
      s1_cnt_r <= CNT_W'(count_nxt);
    end
    if (adv) begin
      out_removed_r <= s1_rem_r ? rem_out : '0;
      out_st_r      <= s1_st_r;
      out_cnt_r     <= s1_cnt_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.entry_count   = out_cnt_r;

  `SAL_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `SAL_ASSERT_NXT(a_fail_hold, clk, rst_n, acc && (st != ST_OK), $stable(count_r))
  `SAL_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid_r && (out_st_r != ST_OK), out_removed_r == '0)

endmodule

`default_nettype wire
